### design/wsl_pkg.sv
// Shared constants and types of the Wilson score lower bound block.
// Used by the quantile sequencer, the shared multiplier, the item pipeline and the top level.
// Depends on nothing.
`default_nettype none

package wsl_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int POLY_TERMS = 11;
	localparam int ZQ_W       = 28;
	localparam int ZSQ_W      = 32;
	localparam int NUM_W      = 57;
	localparam int QDIV_STEPS = 33;
	localparam int ROOT_STEPS = 32;

	localparam logic [15:0] ALPHA_RESET = 16'd3277;
	localparam logic [63:0] LN2_Q32     = 64'd2977044472;

	// Register index decoded from the word address.
	localparam logic REG_ALPHA = 1'b0;

	// Polynomial coefficients in Q.48, two's complement, lowest order first.
	localparam logic signed [63:0] COEF_Q48 [POLY_TERMS] = '{
		64'sd442139848581985, 64'sd10434243345070, -64'sd235435623166,
		-64'sd63358530394, 64'sd1925631761, 64'sd1639377400, -64'sd294218748,
		64'sd23533946, -64'sd909469, 64'sd10296, 64'sd195
	};

	typedef enum logic [2:0] {
		SH_TRUNC31 = 3'b001,
		SH_RND32   = 3'b010,
		SH_RND48   = 3'b100
	} shift_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
		shift_t      sh;
	} mul_req_t;

	typedef struct packed {
		logic              ready;
		logic [ZSQ_W-1:0]  zsq;
		logic [ZQ_W-1:0]   zq;
	} zcoef_t;

endpackage

`default_nettype wire

### design/wsl_mulshr.sv
// Sequential 64x64 multiplier with a truncating or rounding right shift.
// Built from one 32x32 multiplier over four partial products.
// Depends on wsl_pkg.
`default_nettype none

module wsl_mulshr (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wsl_pkg::mul_req_t req,
	output logic                   done,
	output logic [63:0]            res
);

	logic            busy_q;
	logic [2:0]      cnt_q;
	logic            ppv_q;
	logic            done_q;
	logic [1:0]      off_q;
	logic [63:0]     pp_q;
	logic [127:0]    acc_q;
	logic [63:0]     a_q;
	logic [63:0]     b_q;
	wsl_pkg::shift_t sh_q;
	logic [63:0]     res_q;

	logic [31:0]  ah_w;
	logic [31:0]  bh_w;
	logic [127:0] ppx_w;
	logic [127:0] sum_w;
	logic [63:0]  rnd_w;

	always_comb begin
		ah_w = cnt_q[0] ? a_q[63:32] : a_q[31:0];
		bh_w = cnt_q[1] ? b_q[63:32] : b_q[31:0];
		case (off_q)
			2'd0: ppx_w = {64'd0, pp_q};
			2'd1: ppx_w = {32'd0, pp_q, 32'd0};
			2'd2: ppx_w = {pp_q, 64'd0};
			default: ppx_w = '0;
		endcase
		case (sh_q)
			wsl_pkg::SH_TRUNC31: begin
				sum_w = acc_q;
				rnd_w = sum_w[94:31];
			end
			wsl_pkg::SH_RND32: begin
				sum_w = acc_q + (128'd1 << 31);
				rnd_w = sum_w[95:32];
			end
			wsl_pkg::SH_RND48: begin
				sum_w = acc_q + (128'd1 << 47);
				rnd_w = sum_w[111:48];
			end
			default: begin
				sum_w = acc_q;
				rnd_w = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			ppv_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			ppv_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (busy_q) begin
			ppv_q  <= (cnt_q < 3'd4);
			cnt_q  <= cnt_q + 3'd1;
			done_q <= (cnt_q == 3'd5);
			if (cnt_q == 3'd5) begin
				busy_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			sh_q  <= req.sh;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) begin
				pp_q  <= {32'd0, ah_w} * {32'd0, bh_w};
				off_q <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
			end
			if (ppv_q) begin
				acc_q <= acc_q + ppx_w;
			end
			if (cnt_q == 3'd5) begin
				res_q <= rnd_w;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

### design/wsl_quantile.sv
// Sequencer that derives z^2 and z from the alpha register.
// Runs the log and the polynomial on the shared multiplier, then a bit-serial square root.
// Depends on wsl_pkg and wsl_mulshr.
`default_nettype none

module wsl_quantile (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [15:0]      alpha,
	input  wire logic             start,
	output wsl_pkg::zcoef_t       z
);

	typedef enum logic [11:0] {
		Q_ALPHA = 12'b000000000001,
		Q_NORM  = 12'b000000000010,
		Q_SQ    = 12'b000000000100,
		Q_SQW   = 12'b000000001000,
		Q_W3    = 12'b000000010000,
		Q_W3W   = 12'b000000100000,
		Q_HM    = 12'b000001000000,
		Q_HW    = 12'b000010000000,
		Q_Z2    = 12'b000100000000,
		Q_Z2W   = 12'b001000000000,
		Q_ROOT  = 12'b010000000000,
		Q_DONE  = 12'b100000000000
	} qstate_t;

	qstate_t     state_q;
	logic [31:0] prod_q;
	logic [4:0]  e_q;
	logic [31:0] m_q;
	logic [31:0] frac_q;
	logic [4:0]  i_q;
	logic [63:0] w3_q;
	logic [63:0] acc_q;
	logic [3:0]  k_q;
	logic        neg_q;
	logic [63:0] x_q;
	logic [33:0] srem_q;
	logic [31:0] root_q;
	logic [4:0]  j_q;
	logic [wsl_pkg::ZQ_W-1:0]  zq_q;
	logic [wsl_pkg::ZSQ_W-1:0] zsq_q;

	wsl_pkg::mul_req_t req_w;
	logic        mdone_w;
	logic [63:0] mres_w;

	logic [16:0] a17_w;
	logic [33:0] prod34_w;
	logic [63:0] t_w;
	logic [63:0] mag_w;
	logic [63:0] w1_w;
	logic [63:0] hp_w;
	logic [63:0] accn_w;
	logic [35:0] r2_w;
	logic [35:0] trial_w;
	logic [35:0] rdiff_w;
	logic        rge_w;
	logic [63:0] z2r_w;

	wsl_mulshr u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_w),
		.done   (mdone_w),
		.res    (mres_w)
	);

	always_comb begin
		// Alpha of zero is taken as the smallest nonzero value.
		a17_w    = (alpha == 16'd0) ? 17'd1 : {1'b0, alpha};
		prod34_w = {17'd0, a17_w} * (34'd131072 - {17'd0, a17_w});
		t_w      = (64'd32 << 32) - {27'd0, e_q, frac_q};
		mag_w    = acc_q[63] ? (64'd0 - acc_q) : acc_q;
		w1_w     = acc_q[63] ? 64'd0 : acc_q;
		hp_w     = neg_q ? (64'd0 - mres_w) : mres_w;
		accn_w   = hp_w + $unsigned(wsl_pkg::COEF_Q48[4'(k_q - 4'd1)]);
		r2_w     = {srem_q, x_q[63:62]};
		trial_w  = {2'b00, root_q, 2'b01};
		rge_w    = (r2_w >= trial_w);
		rdiff_w  = r2_w - trial_w;
		z2r_w    = mres_w + 64'd128;

		req_w.start = 1'b0;
		req_w.a     = {32'd0, m_q};
		req_w.b     = {32'd0, m_q};
		req_w.sh    = wsl_pkg::SH_TRUNC31;
		case (state_q)
			Q_SQ: begin
				req_w.start = 1'b1;
			end
			Q_W3: begin
				req_w.start = 1'b1;
				req_w.a     = t_w;
				req_w.b     = wsl_pkg::LN2_Q32;
				req_w.sh    = wsl_pkg::SH_RND32;
			end
			Q_HM: begin
				req_w.start = 1'b1;
				req_w.a     = mag_w;
				req_w.b     = w3_q;
				req_w.sh    = wsl_pkg::SH_RND32;
			end
			Q_Z2: begin
				req_w.start = 1'b1;
				req_w.a     = w1_w;
				req_w.b     = w3_q;
				req_w.sh    = wsl_pkg::SH_RND48;
			end
			default: begin
				req_w.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Q_ALPHA;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else if (start) begin
			state_q <= Q_ALPHA;
		end else begin
			case (state_q)
				Q_ALPHA: state_q <= Q_NORM;
				Q_NORM: begin
					if (prod_q[31]) begin
						state_q <= Q_SQ;
						i_q     <= '0;
					end
				end
				Q_SQ: state_q <= Q_SQW;
				Q_SQW: begin
					if (mdone_w) begin
						i_q     <= i_q + 5'd1;
						state_q <= (i_q == 5'd31) ? Q_W3 : Q_SQ;
					end
				end
				Q_W3: state_q <= Q_W3W;
				Q_W3W: begin
					if (mdone_w) begin
						k_q     <= 4'd10;
						state_q <= Q_HM;
					end
				end
				Q_HM: state_q <= Q_HW;
				Q_HW: begin
					if (mdone_w) begin
						k_q     <= k_q - 4'd1;
						state_q <= (k_q == 4'd1) ? Q_Z2 : Q_HM;
					end
				end
				Q_Z2: state_q <= Q_Z2W;
				Q_Z2W: begin
					if (mdone_w) begin
						j_q     <= '0;
						state_q <= Q_ROOT;
					end
				end
				Q_ROOT: begin
					j_q <= j_q + 5'd1;
					if (j_q == 5'd31) begin
						state_q <= Q_DONE;
					end
				end
				Q_DONE: state_q <= Q_DONE;
				default: state_q <= Q_ALPHA;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			Q_ALPHA: begin
				prod_q <= prod34_w[31:0];
				e_q    <= 5'd31;
			end
			Q_NORM: begin
				if (prod_q[31]) begin
					m_q    <= prod_q;
					frac_q <= '0;
				end else begin
					prod_q <= {prod_q[30:0], 1'b0};
					e_q    <= e_q - 5'd1;
				end
			end
			Q_SQW: begin
				// One fraction bit of the log per squaring of the mantissa.
				if (mdone_w) begin
					if (mres_w[32]) begin
						m_q         <= mres_w[32:1];
						frac_q[~i_q] <= 1'b1;
					end else begin
						m_q <= mres_w[31:0];
					end
				end
			end
			Q_W3W: begin
				if (mdone_w) begin
					w3_q  <= mres_w;
					acc_q <= $unsigned(wsl_pkg::COEF_Q48[wsl_pkg::POLY_TERMS-1]);
				end
			end
			Q_HM: neg_q <= acc_q[63];
			Q_HW: begin
				if (mdone_w) begin
					acc_q <= accn_w;
				end
			end
			Q_Z2W: begin
				if (mdone_w) begin
					zsq_q  <= z2r_w[39:8];
					x_q    <= {mres_w[47:0], 16'd0};
					srem_q <= '0;
					root_q <= '0;
				end
			end
			Q_ROOT: begin
				x_q    <= {x_q[61:0], 2'b00};
				srem_q <= rge_w ? rdiff_w[33:0] : r2_w[33:0];
				root_q <= {root_q[30:0], rge_w};
				if (j_q == 5'd31) begin
					zq_q <= {root_q[wsl_pkg::ZQ_W-2:0], rge_w};
				end
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

	assign z.ready = (state_q == Q_DONE);
	assign z.zsq   = zsq_q;
	assign z.zq    = zq_q;

endmodule

`default_nettype wire

### design/wsl_pipe.sv
// Item datapath of the Wilson lower bound: division, square root, final division.
// A stall enable moves all stages at once; one item can enter every cycle while it is high.
// Depends on wsl_pkg.
`default_nettype none

module wsl_pipe (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_vld,
	input  wire logic [31:0]     p,
	input  wire logic [31:0]     n,
	input  wire wsl_pkg::zcoef_t z,
	output logic                 out_vld,
	output logic [15:0]          lower_bound,
	output logic                 empty_flag,
	output logic                 clamp_flag
);

	localparam int NW = wsl_pkg::NUM_W;
	localparam int FB = wsl_pkg::FRAC_BITS;

	typedef struct packed {
		logic        vld;
		logic        empty;
		logic        clamp;
		logic [31:0] p;
		logic [31:0] n;
		logic [32:0] rem;
		logic [32:0] quot;
	} qdiv_t;

	typedef struct packed {
		logic        vld;
		logic        empty;
		logic        clamp;
		logic [31:0] p;
		logic [31:0] n;
		logic [63:0] pq;
	} pmul_t;

	typedef struct packed {
		logic        vld;
		logic        empty;
		logic        clamp;
		logic        big;
		logic [31:0] p;
		logic [31:0] n;
		logic [63:0] x;
		logic [33:0] rem;
		logic [31:0] root;
	} sqrt_t;

	typedef struct packed {
		logic        vld;
		logic        empty;
		logic        clamp;
		logic        big;
		logic [31:0] p;
		logic [31:0] n;
		logic [59:0] prod;
	} zr_t;

	typedef struct packed {
		logic          vld;
		logic          empty;
		logic          clamp;
		logic [NW-1:0] base;
		logic [NW-1:0] zr;
		logic [NW-1:0] den;
	} num_t;

	typedef struct packed {
		logic          vld;
		logic          empty;
		logic          clamp;
		logic [NW-1:0] den;
		logic [NW-1:0] rem;
		logic [FB-1:0] quot;
	} fdiv_t;

	typedef struct packed {
		logic        vld;
		logic        empty;
		logic        clamp;
		logic [15:0] lb;
	} res_t;

	function automatic qdiv_t qdiv_step(qdiv_t x, logic first);
		qdiv_t       y;
		logic [32:0] r;
		logic        ge;
		y      = x;
		r      = first ? x.rem : {x.rem[31:0], 1'b0};
		ge     = (r >= {1'b0, x.n});
		y.rem  = ge ? (r - {1'b0, x.n}) : r;
		y.quot = {x.quot[31:0], ge};
		return y;
	endfunction

	function automatic sqrt_t sqrt_step(sqrt_t x);
		sqrt_t       y;
		logic [35:0] r2;
		logic [35:0] trial;
		logic [35:0] d;
		logic        ge;
		y      = x;
		r2     = {x.rem, x.x[63:62]};
		trial  = {2'b00, x.root, 2'b01};
		d      = r2 - trial;
		ge     = (r2 >= trial);
		y.rem  = ge ? d[33:0] : r2[33:0];
		y.root = {x.root[30:0], ge};
		y.x    = {x.x[61:0], 2'b00};
		return y;
	endfunction

	function automatic fdiv_t fdiv_step(fdiv_t x);
		fdiv_t       y;
		logic [NW:0] r;
		logic [NW:0] d;
		logic        ge;
		y      = x;
		r      = {x.rem, 1'b0};
		d      = r - {1'b0, x.den};
		ge     = (r >= {1'b0, x.den});
		y.rem  = ge ? d[NW-1:0] : r[NW-1:0];
		y.quot = {x.quot[FB-2:0], ge};
		return y;
	endfunction

	qdiv_t qd_s [0:wsl_pkg::QDIV_STEPS];
	pmul_t pm_s1;
	sqrt_t sq_s [0:wsl_pkg::ROOT_STEPS];
	zr_t   zr_s1;
	num_t  nm_s1;
	fdiv_t fd_s [0:FB];
	res_t  out_s1;

	qdiv_t         qin_w;
	logic [31:0]   pc_w;
	sqrt_t         sin_w;
	logic [63:0]   vsum_w;
	logic [55:0]   s_w;
	num_t          nin_w;
	logic [60:0]   zsum_w;
	fdiv_t         fin_w;
	logic [NW-1:0] num_w;
	res_t          rin_w;
	logic [FB:0]   q17_w;
	logic [NW:0]   rem2_w;

	always_comb begin
		// Entry: flags, saturation of the positives, first remainder.
		qin_w.vld   = in_vld;
		qin_w.empty = (n == 32'd0);
		qin_w.clamp = (p > n);
		pc_w        = qin_w.clamp ? n : p;
		qin_w.p     = pc_w;
		qin_w.n     = n;
		qin_w.rem   = {1'b0, n - pc_w};
		qin_w.quot  = '0;

		// V = p*q in Q.24, then S and the range choice of the root operand.
		vsum_w    = pm_s1.pq + 64'd128;
		s_w       = vsum_w[63:8] + {26'd0, z.zsq[31:2]};
		sin_w.vld   = pm_s1.vld;
		sin_w.empty = pm_s1.empty;
		sin_w.clamp = pm_s1.clamp;
		sin_w.p     = pm_s1.p;
		sin_w.n     = pm_s1.n;
		sin_w.big   = |s_w[55:40];
		sin_w.x     = sin_w.big ? {8'd0, s_w} : {s_w[39:0], 24'd0};
		sin_w.rem   = '0;
		sin_w.root  = '0;

		// Large S takes the root without the 2^24 scale and shifts it by 12.
		zsum_w      = {1'b0, zr_s1.prod} + (zr_s1.big ? 61'd2048 : 61'd8388608);
		nin_w.vld   = zr_s1.vld;
		nin_w.empty = zr_s1.empty;
		nin_w.clamp = zr_s1.clamp;
		nin_w.zr    = zr_s1.big ? {8'd0, zsum_w[60:12]} : {20'd0, zsum_w[60:24]};
		nin_w.base  = {1'b0, zr_s1.p, 24'd0} + {26'd0, z.zsq[31:1]};
		nin_w.den   = {1'b0, zr_s1.n, 24'd0} + {25'd0, z.zsq};

		num_w       = (nm_s1.base > nm_s1.zr) ? (nm_s1.base - nm_s1.zr) : '0;
		fin_w.vld   = nm_s1.vld;
		fin_w.empty = nm_s1.empty;
		fin_w.clamp = nm_s1.clamp;
		fin_w.den   = nm_s1.den;
		fin_w.rem   = (num_w > nm_s1.den) ? nm_s1.den : num_w;
		fin_w.quot  = '0;

		// Round half up, saturate a bound of one, force zero for an empty total.
		rem2_w      = {fd_s[FB].rem, 1'b0};
		q17_w       = {1'b0, fd_s[FB].quot} + {{FB{1'b0}}, (rem2_w >= {1'b0, fd_s[FB].den})};
		rin_w.vld   = fd_s[FB].vld;
		rin_w.empty = fd_s[FB].empty;
		rin_w.clamp = fd_s[FB].clamp;
		if (fd_s[FB].empty) begin
			rin_w.lb = '0;
		end else if (q17_w[FB]) begin
			rin_w.lb = '1;
		end else begin
			rin_w.lb = 16'(q17_w[FB-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qd_s[0] <= '0;
			pm_s1   <= '0;
			sq_s[0] <= '0;
			zr_s1   <= '0;
			nm_s1   <= '0;
			fd_s[0] <= '0;
			out_s1  <= '0;
		end else if (en) begin
			qd_s[0]      <= qin_w;
			pm_s1.vld    <= qd_s[wsl_pkg::QDIV_STEPS].vld;
			pm_s1.empty  <= qd_s[wsl_pkg::QDIV_STEPS].empty;
			pm_s1.clamp  <= qd_s[wsl_pkg::QDIV_STEPS].clamp;
			pm_s1.p      <= qd_s[wsl_pkg::QDIV_STEPS].p;
			pm_s1.n      <= qd_s[wsl_pkg::QDIV_STEPS].n;
			pm_s1.pq     <= {32'd0, qd_s[wsl_pkg::QDIV_STEPS].p}
			                * {32'd0, qd_s[wsl_pkg::QDIV_STEPS].quot[31:0]};
			sq_s[0]      <= sin_w;
			zr_s1.vld    <= sq_s[wsl_pkg::ROOT_STEPS].vld;
			zr_s1.empty  <= sq_s[wsl_pkg::ROOT_STEPS].empty;
			zr_s1.clamp  <= sq_s[wsl_pkg::ROOT_STEPS].clamp;
			zr_s1.big    <= sq_s[wsl_pkg::ROOT_STEPS].big;
			zr_s1.p      <= sq_s[wsl_pkg::ROOT_STEPS].p;
			zr_s1.n      <= sq_s[wsl_pkg::ROOT_STEPS].n;
			zr_s1.prod   <= {32'd0, z.zq} * {28'd0, sq_s[wsl_pkg::ROOT_STEPS].root};
			nm_s1        <= nin_w;
			fd_s[0]      <= fin_w;
			out_s1       <= rin_w;
		end
	end

	for (genvar k = 1; k <= wsl_pkg::QDIV_STEPS; k++) begin : g_qdiv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				qd_s[k] <= '0;
			end else if (en) begin
				qd_s[k] <= qdiv_step(qd_s[k-1], 1'(k == 1));
			end
		end
	end

	for (genvar k = 1; k <= wsl_pkg::ROOT_STEPS; k++) begin : g_sqrt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_s[k] <= '0;
			end else if (en) begin
				sq_s[k] <= sqrt_step(sq_s[k-1]);
			end
		end
	end

	for (genvar k = 1; k <= FB; k++) begin : g_fdiv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fd_s[k] <= '0;
			end else if (en) begin
				fd_s[k] <= fdiv_step(fd_s[k-1]);
			end
		end
	end

	assign out_vld     = out_s1.vld;
	assign lower_bound = out_s1.lb;
	assign empty_flag  = out_s1.empty;
	assign clamp_flag  = out_s1.clamp;

endmodule

`default_nettype wire

### design/wilson_score_lower_bound.sv
// Throughput: one item per cycle; the pipeline moves as one and halts only while a result waits.
// After reset and after every write of confidence_alpha the z unit runs 32 squarings and
// 12 other products on one shared multiplier, plus a root; s_tready stays low meanwhile.
// Reset loads alpha = 3277 and empties the pipeline.
// Depends on wsl_pkg, wsl_quantile and wsl_pipe.
`default_nettype none

module wilson_score_lower_bound (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input items.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // [31:0] positive_count, [63:32] total_count
	// Result items.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] lower_bound
	output logic [1:0]       m_tuser,   // [0] empty_flag, [1] clamp_flag
	// Configuration.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [15:0]     alpha_q;
	logic            wr_w;
	logic            en_w;
	logic            in_vld_w;
	wsl_pkg::zcoef_t zc_w;
	logic            out_vld_w;
	logic [15:0]     lb_w;
	logic            empty_w;
	logic            clamp_w;

	// The register file holds one register; the word address selects it, and
	// writes elsewhere are dropped.
	assign pready = 1'b1;
	assign wr_w   = psel && penable && pwrite && pready && (paddr[2] == wsl_pkg::REG_ALPHA);
	assign prdata = (paddr[2] == wsl_pkg::REG_ALPHA) ? {16'd0, alpha_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= wsl_pkg::ALPHA_RESET;
		end else if (wr_w) begin
			alpha_q <= pwdata[15:0];
		end
	end

	// z depends only on alpha, so it is derived once per write by a slow
	// sequencer instead of per item; the item pipeline reads it as a constant.
	wsl_quantile u_quant (
		.clk    (clk),
		.arst_n (arst_n),
		.alpha  (alpha_q),
		.start  (wr_w),
		.z      (zc_w)
	);

	// The whole pipeline advances unless the output register holds a result
	// that is not taken. The last stage is that output register, so a new item
	// still enters while earlier results are in flight.
	assign en_w     = !out_vld_w || m_tready;
	assign s_tready = en_w && zc_w.ready;
	assign in_vld_w = s_tvalid && s_tready;

	wsl_pipe u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en_w),
		.in_vld      (in_vld_w),
		.p           (s_tdata[31:0]),
		.n           (s_tdata[63:32]),
		.z           (zc_w),
		.out_vld     (out_vld_w),
		.lower_bound (lb_w),
		.empty_flag  (empty_w),
		.clamp_flag  (clamp_w)
	);

	assign m_tvalid = out_vld_w;
	assign m_tdata  = lb_w;
	assign m_tuser  = {clamp_w, empty_w};

endmodule

`default_nettype wire
